FILE: design/dmtq_pkg.sv
// ----------------------------------------------------------------------------
// dmtq_pkg
// Shared types and codes for the delayed message time queue.
// ----------------------------------------------------------------------------
package dmtq_pkg;

    localparam int HandleW = 16;
    localparam int TimeW   = 32;
    localparam int StatusW = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
    localparam logic [StatusW-1:0] ST_DELIVERED = 3'd1;
    localparam logic [StatusW-1:0] ST_EMPTY     = 3'd2;
    localparam logic [StatusW-1:0] ST_NOT_DUE   = 3'd3;
    localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [HandleW-1:0] handle;
        logic [TimeW-1:0]   stamp;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_HEAD  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

FILE: design/delayed_message_time_queue_unit.sv
// ----------------------------------------------------------------------------
// delayed_message_time_queue_unit
// Time-sorted queue of delayed messages held in a circular buffer memory.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields, lowest bit first
//  s_axis  | in  | opcode[0] message_handle[16:1] send_time[48:17] now_time[80:49]
//  m_axis  | out | status[2:0] out_handle[18:3] out_time[50:19] now_empty[51]
//          |     | head_handle[67:52] head_time[99:68]
//
// One transfer in gives one transfer out; one item is worked on at a time.
// A poll goes to S_DONE, through S_HEAD first when a new head is read from the
// memory. An insert needs no walk into an empty or full queue; else it walks
// down from the tail in S_SHIFT, which moves each stored entry later than the
// new one up one place, one entry a cycle through the single memory read port.
// Reset empties the queue at once; memory contents need no clearing.
// A stalled result waits in the output register while the next item is taken;
// that item then waits in S_DONE, input held off, until the register is free.
module delayed_message_time_queue_unit
    import dmtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode, message_handle, send_time, now_time, zero fill
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, out_handle, out_time, now_empty, head_handle, head_time, zero fill
    output logic [103:0] m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    // input fields
    logic               in_op;
    t_entry             in_entry;
    logic [TimeW-1:0]   in_now;

    assign in_op           = s_axis_tdata[0];
    assign in_entry.handle = s_axis_tdata[16:1];
    assign in_entry.stamp  = s_axis_tdata[48:17];
    assign in_now          = s_axis_tdata[80:49];

    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd_data;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    t_entry             r_head_ent, n_head_ent;
    t_entry             r_new, n_new;
    logic [AW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_left, n_left;
    logic [StatusW-1:0] r_status, n_status;
    t_entry             r_dlv, n_dlv;
    logic               r_out_valid, n_out_valid;
    logic [103:0]       r_out_data, n_out_data;

    logic [AW:0]        tail_sum;
    logic [AW-1:0]      tail;
    logic               out_free;
    logic               in_xfer;
    t_entry             head_show;

    assign tail_sum = {1'b0, r_head} + (AW + 1)'(r_count);
    assign tail     = (tail_sum >= (AW + 1)'(QUEUE_DEPTH))
                    ? AW'(tail_sum - (AW + 1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
    assign out_free = !r_out_valid || m_axis_tready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign head_show = (r_count == '0) ? '0 : r_head_ent;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_head_ent  = r_head_ent;
        n_new       = r_new;
        n_pos       = r_pos;
        n_left      = r_left;
        n_status    = r_status;
        n_dlv       = r_dlv;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        rd_addr     = f_prev(tail);
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_new;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_dlv   = '0;
                    n_state = S_DONE;
                    if (in_op == OP_INSERT) begin
                        n_status = ST_INSERTED;
                        if (r_count == FULL_CNT) begin
                            n_status = ST_FULL;
                        end else if (r_count == '0) begin
                            wr_en      = 1'b1;
                            wr_addr    = r_head;
                            wr_data    = in_entry;
                            n_head_ent = in_entry;
                            n_count    = CW'(1);
                        end else begin
                            // walk down from the tail, shifting later entries up
                            n_count = r_count + 1'b1;
                            n_pos   = tail;
                            n_left  = r_count;
                            n_new   = in_entry;
                            n_state = S_SHIFT;
                        end
                    end else begin
                        rd_addr = f_next(r_head);
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (r_head_ent.stamp > in_now) begin
                            n_status = ST_NOT_DUE;
                        end else begin
                            n_status = ST_DELIVERED;
                            n_dlv    = r_head_ent;
                            n_head   = f_next(r_head);
                            n_count  = r_count - 1'b1;
                            if (r_count != CW'(1)) begin
                                n_state = S_HEAD;
                            end
                        end
                    end
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                rd_addr = f_prev(f_prev(r_pos));
                if (r_rd_data.stamp > r_new.stamp) begin
                    wr_data = r_rd_data;
                    n_pos   = f_prev(r_pos);
                    n_left  = r_left - 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    wr_data = r_new;
                    n_state = S_DONE;
                end
            end
            S_PLACE: begin
                // every stored entry was later: the new one becomes the head
                wr_en      = 1'b1;
                wr_addr    = r_pos;
                wr_data    = r_new;
                n_head_ent = r_new;
                n_state    = S_DONE;
            end
            S_HEAD: begin
                n_head_ent = r_rd_data;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, head_show.stamp, head_show.handle,
                                   (r_count == '0), r_dlv.stamp, r_dlv.handle,
                                   r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_ent <= n_head_ent;
        r_new      <= n_new;
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_status   <= n_status;
        r_dlv      <= n_dlv;
        r_out_data <= n_out_data;
    end

endmodule

FILE: tb/dmtq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtq_checker
// Watches both streams of the delayed message time queue. Every input
// transfer goes through a local sorted queue, which gives the report that
// must follow. Output transfers are compared in order, field by field.
// Reports the failure count and the number of reports still owed.
// ----------------------------------------------------------------------------
module dmtq_checker
    import dmtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_tvalid,
    input  logic         i_in_tready,
    // opcode, message_handle, send_time, now_time, zero fill
    input  logic [87:0]  i_in_tdata,
    input  logic         i_out_tvalid,
    input  logic         i_out_tready,
    // status, out_handle, out_time, now_empty, head_handle, head_time, zero fill
    input  logic [103:0] i_out_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        logic [StatusW-1:0] status;
        logic [HandleW-1:0] out_handle;
        logic [TimeW-1:0]   out_time;
        logic               now_empty;
        logic [HandleW-1:0] head_handle;
        logic [TimeW-1:0]   head_time;
    } t_report;

    t_entry      timers [QUEUE_DEPTH];
    int unsigned stored;
    t_report     owed_reports [$];
    int          mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        stored       = 0;
    end

    function automatic t_report unpack_report(input logic [103:0] d);
        t_report r;
        r.status      = d[2:0];
        r.out_handle  = d[18:3];
        r.out_time    = d[50:19];
        r.now_empty   = d[51];
        r.head_handle = d[67:52];
        r.head_time   = d[99:68];
        return r;
    endfunction

    // Apply one operation to the local queue and work out its report
    task automatic apply_queue_op(input logic [87:0] d, output t_report r);
        logic               op;
        logic [HandleW-1:0] handle;
        logic [TimeW-1:0]   send;
        logic [TimeW-1:0]   now;
        int unsigned        pos;
        op     = d[0];
        handle = d[16:1];
        send   = d[48:17];
        now    = d[80:49];
        r      = '{default: '0};
        if (op == OP_INSERT) begin
            if (stored >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // place after every entry due at or before the new one
                pos = 0;
                while (pos < stored && timers[pos].stamp <= send) pos++;
                for (int unsigned i = stored; i > pos; i--) timers[i] = timers[i-1];
                timers[pos].handle = handle;
                timers[pos].stamp  = send;
                stored++;
                r.status = ST_INSERTED;
            end
        end else if (stored == 0) begin
            r.status = ST_EMPTY;
        end else if (timers[0].stamp > now) begin
            r.status = ST_NOT_DUE;
        end else begin
            r.status     = ST_DELIVERED;
            r.out_handle = timers[0].handle;
            r.out_time   = timers[0].stamp;
            for (int unsigned i = 1; i < stored; i++) timers[i-1] = timers[i];
            stored--;
        end
        r.now_empty = (stored == 0);
        if (stored != 0) begin
            r.head_handle = timers[0].handle;
            r.head_time   = timers[0].stamp;
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        if (!i_rst_n) begin
            stored = 0;
            owed_reports.delete();
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                apply_queue_op(i_in_tdata, want);
                owed_reports.push_back(want);
            end
            if (i_out_tvalid && i_out_tready) begin
                got = unpack_report(i_out_tdata);
                if (owed_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report: st=%0d oh=%h ot=%h em=%b hh=%h ht=%h",
                                 got.status, got.out_handle, got.out_time,
                                 got.now_empty, got.head_handle, got.head_time);
                end else begin
                    want = owed_reports.pop_front();
                    if (got.status !== want.status || got.out_handle !== want.out_handle
                        || got.out_time !== want.out_time || got.now_empty !== want.now_empty
                        || got.head_handle !== want.head_handle
                        || got.head_time !== want.head_time) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("report mismatch, want: st=%0d oh=%h ot=%h em=%b hh=%h ht=%h",
                                     want.status, want.out_handle, want.out_time,
                                     want.now_empty, want.head_handle, want.head_time);
                            $display("                 got:  st=%0d oh=%h ot=%h em=%b hh=%h ht=%h",
                                     got.status, got.out_handle, got.out_time,
                                     got.now_empty, got.head_handle, got.head_time);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= owed_reports.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the delayed message time queue: a directed pass over empty,
// equal-time, due and full cases, then random inserts and polls in phases
// that fill, drain and mix the queue, with random idling on both streams,
// a long output hold-off and a full drain pause. Checking sits in dmtq_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import dmtq_pkg::*;

    localparam int Depth     = 16;
    localparam int IdleLimit = 5000;
    localparam int HoldLen   = 300;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // opcode, message_handle, send_time, now_time, zero fill
    logic [87:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, out_handle, out_time, now_empty, head_handle, head_time, zero fill
    logic [103:0] m_axis_tdata;

    int fail_count;
    int pending;
    int holds_asked = 0;
    int holds_served = 0;
    bit calm = 1'b0;
    int idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    delayed_message_time_queue_unit #(.QUEUE_DEPTH(Depth)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dmtq_checker #(.QUEUE_DEPTH(Depth)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random back-pressure, or a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (holds_asked != holds_served) begin
                m_axis_tready <= 1'b0;
                repeat (HoldLen) @(negedge i_clk);
                holds_served++;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 26);
            end
        end
    end

    // Abort when nothing moves on either stream for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IdleLimit) begin
                $display("tb_top NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_item(input logic op, input logic [HandleW-1:0] handle,
                             input logic [TimeW-1:0] send, input logic [TimeW-1:0] now);
        while (!calm && $urandom_range(99) < 26) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, now, send, handle, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic insert_msg(input logic [HandleW-1:0] handle, input logic [TimeW-1:0] send);
        send_item(OP_INSERT, handle, send, $urandom);
    endtask

    task automatic poll_msg(input logic [TimeW-1:0] now);
        send_item(OP_POLL, HandleW'($urandom_range(65535)), $urandom, now);
    endtask

    // Hold the sender until every owed report has arrived
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Narrow ranges give equal times and due heads; wide ones reach the extremes
    function automatic logic [TimeW-1:0] pick_time();
        case ($urandom_range(3))
            0: return $urandom_range(63);
            1: return $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(63);
            default: return $urandom_range(1023);
        endcase
    endfunction

    initial begin
        int bias;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty polls, extremes, equal-time order, due boundaries
        poll_msg(32'h0);
        poll_msg(32'hFFFF_FFFF);
        insert_msg(16'h0000, 32'hFFFF_FFFF);
        insert_msg(16'hFFFF, 32'h0);
        insert_msg(16'h0001, 32'd100);
        insert_msg(16'h0002, 32'd100);
        insert_msg(16'h0003, 32'd100);
        poll_msg(32'h0);
        poll_msg(32'd99);
        poll_msg(32'd100);
        poll_msg(32'd100);
        poll_msg(32'd100);
        poll_msg(32'hFFFF_FFFE);
        poll_msg(32'hFFFF_FFFF);
        poll_msg(32'hFFFF_FFFF);
        // fill to the brim, then one more is dropped
        for (int i = 0; i < Depth; i++) insert_msg(HandleW'($urandom_range(65535)), pick_time());
        insert_msg(16'hA5A5, 32'h5A5A_5A5A);
        poll_msg(32'h0);
        wait_drained();

        // random: twelve phases that fill, drain or mix the queue
        for (int blk = 0; blk < 12; blk++) begin
            bias = (blk % 3 == 0) ? 75 : (blk % 3 == 1) ? 25 : 50;
            if (blk == 3) holds_asked++;
            if (blk == 7) wait_drained();
            calm = (blk == 9);
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(99) < bias)
                    insert_msg(HandleW'($urandom_range(65535)), pick_time());
                else
                    poll_msg(pick_time());
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/dmtq_pkg.sv
design/delayed_message_time_queue_unit.sv
tb/dmtq_checker.sv
tb/tb_top.sv
